[src/hrf_pkg.sv]
package hrf_pkg;

	localparam int DefaultMaxRequest = 65536;
	localparam int CfgW = 17;
	localparam int LenW = 17;
	localparam logic [CfgW-1:0] CfgReset = 17'd65536;
	localparam int NameLen = 16;

	localparam logic [7:0] CharCr = 8'h0D;
	localparam logic [7:0] CharLf = 8'h0A;
	localparam logic [7:0] Char0 = 8'h30;
	localparam logic [7:0] Char9 = 8'h39;
	localparam logic [7:0] CharUpA = 8'h41;
	localparam logic [7:0] CharUpZ = 8'h5A;
	localparam logic [7:0] CaseOffset = 8'h20;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CLOSED   = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'b001,
		PH_DIGITS = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h63;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h6C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			4'd14:   c = 8'h3A;
			4'd15:   c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CharUpA && c <= CharUpZ) begin
			r = c + CaseOffset;
		end
		return r;
	endfunction

endpackage

[src/hrf_if.sv]
interface hrf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       peer_closed;

	modport source(output valid, output data_byte, output peer_closed, input ready);
	modport sink(input valid, input data_byte, input peer_closed, output ready);
endinterface

interface hrf_out_if;
	logic                         valid;
	logic                         ready;
	hrf_pkg::status_t             status;
	logic [hrf_pkg::LenW-1:0]     request_length;
	logic [hrf_pkg::LenW-1:0]     body_length;

	modport source(output valid, output status, output request_length, output body_length,
		input ready);
	modport sink(input valid, input status, input request_length, input body_length,
		output ready);
endinterface

[src/http_request_framer_top.sv]
// HTTP/1.1 request framer. The req_in channel carries one beat per stream byte, or a
// beat with peer_closed set when the connection ends. The res_out channel carries one
// beat per finished request: status, total request length and the Content-Length value.
// A request ends at the blank line after the headers plus the declared body bytes.
// Oversized requests and early closes produce an error beat with zero lengths.
// The cfg_we/cfg_wdata port sets the size limit; write it only while the block is idle.
// A beat accepted on req_in is held in an input register until it is processed, and its
// result, if any, is registered into the output register that drives res_out.
// Throughput is one byte per cycle while the framer is not stalled; the header scan, the
// digit accumulation and the body count are all evaluated combinationally between the
// input and output registers. The framer keeps taking new bytes while a result waits, and
// only a byte that produces a result stalls when the previous result has not yet been
// taken.
// Reset clears all framing state and sets the limit to 65536 bytes.
module http_request_framer_top #(
	parameter int MAX_REQUEST = hrf_pkg::DefaultMaxRequest
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [hrf_pkg::CfgW-1:0] cfg_wdata,
	hrf_in_if.sink                   req_in,
	hrf_out_if.source                res_out
);
	import hrf_pkg::*;

	localparam int CW = $clog2(MAX_REQUEST + 2);
	localparam int XW = (CW + 1 > CfgW) ? CW + 1 : CfgW;
	localparam int VW = CW + 4;
	localparam logic [CW-1:0] LenCap = CW'(MAX_REQUEST + 1);
	localparam logic [XW-1:0] MaxX = XW'(MAX_REQUEST);

	logic [CfgW-1:0] max_q;
	logic [XW-1:0]   cfg_x;
	logic [XW-1:0]   limit;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       closed_s1;
	logic       step_go;

	logic [CW-1:0] byte_count_q;
	logic [1:0]    blank_q;
	logic          in_body_q;
	logic [3:0]    name_q;
	phase_t        phase_q;
	logic [CW-1:0] length_q;
	logic [CW-1:0] remain_q;

	logic [CW-1:0] byte_count_n;
	logic [1:0]    blank_n;
	logic          in_body_n;
	logic [3:0]    name_n;
	phase_t        phase_n;
	logic [CW-1:0] length_n;
	logic [CW-1:0] remain_n;

	logic          res_vld;
	status_t       res_status;
	logic [CW-1:0] res_rl;
	logic [CW-1:0] res_bl;

	logic [CW-1:0] bc1;
	logic [CW-1:0] rem_dec;
	logic [7:0]    folded;
	logic [3:0]    digit;
	logic [VW-1:0] acc;
	logic [CW-1:0] len;
	logic [XW-1:0] total;
	logic          blank_hit;
	logic [XW-1:0] rl_x;
	logic [XW-1:0] bl_x;

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= CfgReset;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_comb begin
		cfg_x = XW'(max_q);
		if (max_q == '0) begin
			limit = XW'(1);
		end else if (cfg_x > MaxX) begin
			limit = MaxX;
		end else begin
			limit = cfg_x;
		end
	end

	assign step_go = valid_s1 && (!res_vld || !out_valid_q || res_out.ready);
	assign req_in.ready = !valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_in.ready) begin
			valid_s1 <= req_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_in.valid && req_in.ready) begin
			byte_s1   <= req_in.data_byte;
			closed_s1 <= req_in.peer_closed;
		end
	end

	always_comb begin
		byte_count_n = byte_count_q;
		blank_n      = blank_q;
		in_body_n    = in_body_q;
		name_n       = name_q;
		phase_n      = phase_q;
		length_n     = length_q;
		remain_n     = remain_q;
		res_vld      = 1'b0;
		res_status   = ST_OK;
		res_rl       = '0;
		res_bl       = '0;
		bc1          = byte_count_q + CW'(1);
		rem_dec      = (remain_q != '0) ? remain_q - CW'(1) : '0;
		folded       = fold_case(byte_s1);
		digit        = 4'(byte_s1 - Char0);
		acc          = (VW'(length_q) << 3) + (VW'(length_q) << 1) + VW'(digit);
		len          = '0;
		total        = '0;
		blank_hit    = 1'b0;

		if (closed_s1) begin
			if (byte_count_q != '0) begin
				res_vld    = 1'b1;
				res_status = ST_CLOSED;
				byte_count_n = '0;
				blank_n      = '0;
				in_body_n    = 1'b0;
				name_n       = '0;
				phase_n      = PH_SEARCH;
				length_n     = '0;
				remain_n     = '0;
			end
		end else if (XW'(bc1) > limit) begin
			res_vld    = 1'b1;
			res_status = ST_TOO_LONG;
			byte_count_n = '0;
			blank_n      = '0;
			in_body_n    = 1'b0;
			name_n       = '0;
			phase_n      = PH_SEARCH;
			length_n     = '0;
			remain_n     = '0;
		end else if (in_body_q) begin
			if (rem_dec == '0) begin
				res_vld    = 1'b1;
				res_status = ST_OK;
				res_rl     = bc1;
				res_bl     = length_q;
				byte_count_n = '0;
				blank_n      = '0;
				in_body_n    = 1'b0;
				name_n       = '0;
				phase_n      = PH_SEARCH;
				length_n     = '0;
				remain_n     = '0;
			end else begin
				byte_count_n = bc1;
				remain_n     = rem_dec;
			end
		end else begin
			byte_count_n = bc1;
			case (phase_q)
				PH_SEARCH: begin
					if (folded == name_char(name_q)) begin
						if (name_q == 4'(NameLen - 1)) begin
							phase_n = PH_DIGITS;
							name_n  = '0;
						end else begin
							name_n = name_q + 4'd1;
						end
					end else begin
						name_n = (folded == name_char(4'd0)) ? 4'd1 : 4'd0;
					end
				end
				PH_DIGITS: begin
					if (byte_s1 >= Char0 && byte_s1 <= Char9) begin
						length_n = (acc > VW'(LenCap)) ? LenCap : CW'(acc);
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: begin
				end
			endcase

			case (blank_q)
				2'd0, 2'd2: begin
					blank_n = (byte_s1 == CharCr) ? blank_q + 2'd1 : 2'd0;
				end
				default: begin
					if (byte_s1 == CharLf) begin
						blank_n   = blank_q + 2'd1;
						blank_hit = (blank_q == 2'd3);
					end else begin
						blank_n = (byte_s1 == CharCr) ? 2'd1 : 2'd0;
					end
				end
			endcase

			if (blank_hit) begin
				len   = (phase_n == PH_SEARCH) ? '0 : length_n;
				total = XW'(bc1) + XW'(len);
				blank_n = '0;
				if (total > limit) begin
					res_vld    = 1'b1;
					res_status = ST_TOO_LONG;
				end else if (len == '0) begin
					res_vld    = 1'b1;
					res_status = ST_OK;
					res_rl     = bc1;
				end else begin
					length_n  = len;
					phase_n   = PH_DONE;
					in_body_n = 1'b1;
					remain_n  = len;
				end
				if (res_vld) begin
					byte_count_n = '0;
					in_body_n    = 1'b0;
					name_n       = '0;
					phase_n      = PH_SEARCH;
					length_n     = '0;
					remain_n     = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			blank_q      <= '0;
			in_body_q    <= 1'b0;
			name_q       <= '0;
			phase_q      <= PH_SEARCH;
			length_q     <= '0;
			remain_q     <= '0;
		end else if (step_go) begin
			byte_count_q <= byte_count_n;
			blank_q      <= blank_n;
			in_body_q    <= in_body_n;
			name_q       <= name_n;
			phase_q      <= phase_n;
			length_q     <= length_n;
			remain_q     <= remain_n;
		end
	end

	assign rl_x = XW'(res_rl);
	assign bl_x = XW'(res_bl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go && res_vld) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && res_vld) begin
			res_out.status         <= res_status;
			res_out.request_length <= rl_x[LenW-1:0];
			res_out.body_length    <= bl_x[LenW-1:0];
		end
	end

	assign res_out.valid = out_valid_q;

	a_body_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> phase_q == PH_DONE)
		else $error("body entered without a finished length field");

	a_body_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> remain_q != '0)
		else $error("body state with nothing left to count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(byte_count_q) <= MaxX)
		else $error("byte count beyond the largest request");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && res_vld) |=> byte_count_q == '0 && !in_body_q)
		else $error("framing state not cleared after a result");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.status != ST_OK) |->
			(res_out.request_length == '0 && res_out.body_length == '0))
		else $error("error result carries a nonzero length");

endmodule
